// ----- sv/leus_pkg.sv -----
// Package for the least used entry selector: word types, codes, control structs
// and name helper functions. Depends on nothing.
package leus_pkg;

  localparam int unsigned DEF_ENTRIES    = 128;
  localparam int unsigned DEF_LIST_COUNT = 2;
  localparam int unsigned DEF_COUNT_BITS = 16;

  localparam int unsigned NAME_BYTES = 15;
  localparam int unsigned NAME_W     = 8 * NAME_BYTES;
  localparam int unsigned OFFS_W     = 16;
  localparam int unsigned DCNT_W     = $clog2(OFFS_W + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_GET    = 2'd1,
    CMD_COUNT  = 2'd2,
    CMD_RESET  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        list_type;
    logic [63:0] name_lo;
    logic [55:0] name_hi;
    logic [15:0] start_offset;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  entry_index;
    logic [63:0] out_name_lo;
    logic [55:0] out_name_hi;
    logic [15:0] suffix_number;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    ins_wr;
    logic    div_start;
    logic    div_step;
    logic    scan_start;
    logic    scan_run;
    logic    sel_rd;
    logic    wb;
    logic    clr_start;
    logic    clr_step;
    logic    resp_ld;
    status_e resp_st;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_e cmd;
    logic fill_zero;
    logic fill_full;
    logic div_done;
    logic scan_all;
    logic hit;
    logic clr_last;
  } ctrl_sts_t;

  // bytes after the first zero byte read as zero
  function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] n);
    logic [NAME_W-1:0] r;
    logic              ended;
    r     = n;
    ended = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (n[8*i +: 8] == 8'h00) ended = 1'b1;
      if (ended) r[8*i +: 8] = 8'h00;
    end
    return r;
  endfunction

  // ASCII upper case letters to lower case
  function automatic logic [NAME_W-1:0] fold_name(input logic [NAME_W-1:0] n);
    logic [NAME_W-1:0] r;
    logic [7:0]        c;
    r = n;
    for (int i = 0; i < NAME_BYTES; i++) begin
      c = n[8*i +: 8];
      if (c >= 8'h41 && c <= 8'h5A) r[8*i +: 8] = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ----- sv/leus_ctrl.sv -----
// Controller for the least used entry selector: one-hot state machine issuing
// datapath commands. Depends on leus_pkg.
module leus_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  leus_pkg::ctrl_sts_t sts_i,
  output leus_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_EXEC = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_SCAN = 8'b0000_1000,
    S_SEL  = 8'b0001_0000,
    S_WB   = 8'b0010_0000,
    S_CLR  = 8'b0100_0000,
    S_RESP = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.resp_st = leus_pkg::ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.cmd)
          leus_pkg::CMD_INSERT: begin
            cmd_o.resp_ld = 1'b1;
            if (sts_i.fill_full) begin
              cmd_o.resp_st = leus_pkg::ST_FULL;
            end else begin
              cmd_o.ins_wr = 1'b1;
            end
            state_d = S_RESP;
          end
          leus_pkg::CMD_GET: begin
            if (sts_i.fill_zero) begin
              cmd_o.resp_ld = 1'b1;
              cmd_o.resp_st = leus_pkg::ST_EMPTY;
              state_d       = S_RESP;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          end
          leus_pkg::CMD_COUNT: begin
            if (sts_i.fill_zero) begin
              cmd_o.resp_ld = 1'b1;
              cmd_o.resp_st = leus_pkg::ST_NOT_FOUND;
              state_d       = S_RESP;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
          end
          default: begin
            cmd_o.clr_start = 1'b1;
            state_d         = S_CLR;
          end
        endcase
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.cmd == leus_pkg::CMD_COUNT && sts_i.hit) begin
          state_d = S_SEL;
        end else if (sts_i.scan_all) begin
          if (sts_i.cmd == leus_pkg::CMD_GET) begin
            state_d = S_SEL;
          end else begin
            cmd_o.resp_ld = 1'b1;
            cmd_o.resp_st = leus_pkg::ST_NOT_FOUND;
            state_d       = S_RESP;
          end
        end
      end
      S_SEL: begin
        cmd_o.sel_rd = 1'b1;
        state_d      = S_WB;
      end
      S_WB: begin
        cmd_o.wb      = 1'b1;
        cmd_o.resp_ld = 1'b1;
        state_d       = S_RESP;
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.resp_ld = 1'b1;
          state_d       = S_RESP;
        end
      end
      S_RESP: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/leus_dp.sv -----
// Datapath for the least used entry selector: entry memories, fill counters,
// bit-serial modulo unit, scan registers and result register. Depends on leus_pkg.
module leus_dp #(
  parameter int unsigned ENTRIES    = leus_pkg::DEF_ENTRIES,
  parameter int unsigned LIST_COUNT = leus_pkg::DEF_LIST_COUNT,
  parameter int unsigned COUNT_BITS = leus_pkg::DEF_COUNT_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  leus_pkg::in_word_t  in_word_i,
  input  leus_pkg::ctrl_cmd_t cmd_i,
  output leus_pkg::ctrl_sts_t sts_o,
  output leus_pkg::out_word_t out_word_o
);

  localparam int unsigned IW    = $clog2(ENTRIES);
  localparam int unsigned FW    = $clog2(ENTRIES + 1);
  localparam int unsigned TOTAL = LIST_COUNT * ENTRIES;
  localparam int unsigned AW    = $clog2(TOTAL);
  localparam int unsigned LW    = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int unsigned NW    = leus_pkg::NAME_W;
  localparam int unsigned OW    = leus_pkg::OFFS_W;

  // captured word
  leus_pkg::cmd_e cmd_q;
  logic [LW-1:0]  lsel_q;
  logic [NW-1:0]  name_q;
  logic [NW-1:0]  key_q;
  logic [OW-1:0]  offs_q;

  logic [FW-1:0]  fill_q [LIST_COUNT];
  logic [FW-1:0]  cur_fill;
  logic [AW-1:0]  base_addr;

  // modulo unit
  logic [FW-1:0]               rem_q;
  logic [leus_pkg::DCNT_W-1:0] dcnt_q;
  logic [FW:0]                 rem_sh;
  logic [FW:0]                 rem_sub;

  // scan
  logic [IW-1:0]         ptr_q, rd_idx_q, sel_q;
  logic [FW-1:0]         iss_q, ret_q;
  logic                  rd_vld_q, hit_q;
  logic [COUNT_BITS-1:0] min_q;
  logic                  scan_issue;
  logic                  match;
  logic [FW-1:0]         ptr_inc;

  // memories
  logic [NW-1:0]         name_mem [TOTAL];
  logic [COUNT_BITS-1:0] cnt_mem  [TOTAL];
  logic [NW-1:0]         name_rd_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic [COUNT_BITS-1:0] cnt_bump;
  logic                  rd_en, name_we, cnt_we;
  logic [AW-1:0]         rd_addr, wr_addr, clr_ptr_q;
  logic [COUNT_BITS-1:0] cnt_wd;

  // result
  leus_pkg::out_word_t   res_q;
  logic [IW-1:0]         idx_src;
  logic [IW+6:0]         idx_wide;
  logic [COUNT_BITS+15:0] suf_wide;
  logic                  ok;

  assign cur_fill  = fill_q[lsel_q];
  assign base_addr = AW'(lsel_q) * AW'(ENTRIES);

  assign sts_o.cmd       = cmd_q;
  assign sts_o.fill_zero = (cur_fill == '0);
  assign sts_o.fill_full = (cur_fill == FW'(ENTRIES));
  assign sts_o.div_done  = (dcnt_q == leus_pkg::DCNT_W'(OW));
  assign sts_o.scan_all  = (ret_q == cur_fill);
  assign sts_o.hit       = hit_q;
  assign sts_o.clr_last  = (clr_ptr_q == AW'(TOTAL - 1));

  assign rem_sh  = {rem_q, offs_q[OW-1]};
  assign rem_sub = rem_sh - {1'b0, cur_fill};

  assign scan_issue = cmd_i.scan_run && (iss_q != cur_fill);
  assign ptr_inc    = FW'(ptr_q) + FW'(1);
  assign match      = (leus_pkg::fold_name(name_rd_q) == key_q);
  assign cnt_bump   = (cnt_rd_q == '1) ? cnt_rd_q : cnt_rd_q + COUNT_BITS'(1);

  assign rd_en   = scan_issue || cmd_i.sel_rd;
  assign rd_addr = base_addr + AW'(cmd_i.sel_rd ? sel_q : ptr_q);
  assign name_we = cmd_i.ins_wr;
  assign cnt_we  = cmd_i.ins_wr || cmd_i.wb || cmd_i.clr_step;

  always_comb begin
    if (cmd_i.clr_step) begin
      wr_addr = clr_ptr_q;
    end else if (cmd_i.wb) begin
      wr_addr = base_addr + AW'(sel_q);
    end else begin
      wr_addr = base_addr + AW'(IW'(cur_fill));
    end
    cnt_wd = cmd_i.wb ? cnt_bump : '0;
  end

  always_ff @(posedge clk_i) begin
    if (name_we) name_mem[wr_addr] <= name_q;
    if (rd_en) name_rd_q <= name_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[wr_addr] <= cnt_wd;
    if (rd_en) cnt_rd_q <= cnt_mem[rd_addr];
  end

  // captured word and modulo shift register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= leus_pkg::cmd_e'(in_word_i.cmd);
      lsel_q <= (LIST_COUNT == 1) ? '0 : LW'(in_word_i.list_type);
      name_q <= leus_pkg::canon_name({in_word_i.name_hi, in_word_i.name_lo});
      key_q  <= leus_pkg::fold_name(
                  leus_pkg::canon_name({in_word_i.name_hi, in_word_i.name_lo}));
      offs_q <= in_word_i.start_offset;
    end else if (cmd_i.div_step) begin
      offs_q <= {offs_q[OW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LIST_COUNT; l++) fill_q[l] <= '0;
      rem_q     <= '0;
      dcnt_q    <= '0;
      ptr_q     <= '0;
      iss_q     <= '0;
      ret_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      hit_q     <= 1'b0;
      sel_q     <= '0;
      min_q     <= '0;
      clr_ptr_q <= '0;
    end else begin
      if (cmd_i.ins_wr) fill_q[lsel_q] <= cur_fill + FW'(1);

      if (cmd_i.div_start) begin
        rem_q  <= '0;
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        rem_q  <= rem_sub[FW] ? rem_sh[FW-1:0] : rem_sub[FW-1:0];
        dcnt_q <= dcnt_q + leus_pkg::DCNT_W'(1);
      end

      rd_vld_q <= scan_issue;
      rd_idx_q <= ptr_q;

      if (cmd_i.scan_start) begin
        ptr_q <= (cmd_q == leus_pkg::CMD_GET) ? IW'(rem_q) : '0;
        iss_q <= '0;
        ret_q <= '0;
        hit_q <= 1'b0;
      end else begin
        if (scan_issue) begin
          ptr_q <= (ptr_inc == cur_fill) ? '0 : ptr_q + IW'(1);
          iss_q <= iss_q + FW'(1);
        end
        if (cmd_i.scan_run && rd_vld_q) begin
          ret_q <= ret_q + FW'(1);
          if (cmd_q == leus_pkg::CMD_GET) begin
            // strict compare keeps the first minimum in scan order
            if (ret_q == '0 || cnt_rd_q < min_q) begin
              min_q <= cnt_rd_q;
              sel_q <= rd_idx_q;
            end
          end else if (!hit_q && match) begin
            hit_q <= 1'b1;
            sel_q <= rd_idx_q;
          end
        end
      end

      if (cmd_i.clr_start) begin
        clr_ptr_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_ptr_q <= clr_ptr_q + AW'(1);
      end
    end
  end

  // result word
  assign ok = (cmd_i.resp_st == leus_pkg::ST_OK);

  always_comb begin
    if (cmd_q == leus_pkg::CMD_INSERT) begin
      idx_src = IW'(cur_fill);
    end else begin
      idx_src = sel_q;
    end
  end

  assign idx_wide = (IW + 7)'(idx_src);
  assign suf_wide = (COUNT_BITS + 16)'(cnt_bump);

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_ld) begin
      res_q.status        <= cmd_i.resp_st;
      res_q.entry_index   <= (ok && cmd_q != leus_pkg::CMD_RESET) ? idx_wide[6:0] : '0;
      res_q.out_name_lo   <= '0;
      res_q.out_name_hi   <= '0;
      res_q.suffix_number <= '0;
      if (ok && cmd_q == leus_pkg::CMD_GET) begin
        res_q.out_name_lo <= name_rd_q[63:0];
        res_q.out_name_hi <= name_rd_q[NW-1:64];
        if (cnt_rd_q != '0) res_q.suffix_number <= suf_wide[15:0];
      end
    end
  end

  assign out_word_o = res_q;

endmodule

// ----- sv/least_used_entry_selector_unit.sv -----
// Top level of the least used entry selector: joins controller and datapath.
// Depends on leus_pkg, leus_ctrl and leus_dp.
//
//  channel | direction | handshake              | word
//  input   | in        | in_valid_i / in_ready_o | in_word_i  (leus_pkg::in_word_t)
//  output  | out       | out_valid_o / out_ready_i | out_word_o (leus_pkg::out_word_t)
//
// One word at a time. Insert, and the empty or full cases, load the result straight
// from the command decode. Get: bit-serial modulo, scan, select read, count write-back,
// result; count by name: scan to a hit, then select read and write-back, or to the end
// if not found, one entry memory read per cycle. Reset all counts: one count write per cycle.
// Async reset clears fills; entry memories are not cleared.
// A stalled result holds the block until taken.
module least_used_entry_selector_unit #(
  parameter int unsigned ENTRIES    = leus_pkg::DEF_ENTRIES,
  parameter int unsigned LIST_COUNT = leus_pkg::DEF_LIST_COUNT,
  parameter int unsigned COUNT_BITS = leus_pkg::DEF_COUNT_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  leus_pkg::in_word_t in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output leus_pkg::out_word_t out_word_o
);

  leus_pkg::ctrl_cmd_t cmd;
  leus_pkg::ctrl_sts_t sts;

  leus_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  leus_dp #(
    .ENTRIES    (ENTRIES),
    .LIST_COUNT (LIST_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while a result waits");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready again straight after accepting a word");

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins_wr |-> !sts.fill_full)
    else $error("insert into a full list");

  a_wb_then_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wb |=> out_valid_o)
    else $error("count write-back not followed by a result");

endmodule

// ----- verif/tb.sv -----
// Testbench for least_used_entry_selector_unit: directed table then random words, every result
// checked against an in-bench model of the lists or a typed-in word. Depends on leus_pkg and the unit.
module tb;

  localparam int unsigned NENT  = 128;
  localparam int unsigned NLIST = 2;
  localparam int unsigned CMAX  = 65535;
  localparam int unsigned NRAND = 1130;
  localparam int unsigned NW    = leus_pkg::NAME_W;
  localparam int unsigned NB    = leus_pkg::NAME_BYTES;
  localparam int unsigned RW    = $bits(leus_pkg::out_word_t);
  localparam longint unsigned CYCLE_LIMIT = 2_000_000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  leus_pkg::in_word_t  in_word_i;
  logic                out_valid_o;
  logic                out_ready_i;
  leus_pkg::out_word_t out_word_o;

  least_used_entry_selector_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  // shadow of the lists
  logic [NW-1:0] sh_name [NLIST][NENT];
  int unsigned   sh_count[NLIST][NENT];
  int unsigned   sh_fill [NLIST];

  // typed expectation per word sent, in order
  typedef struct {
    logic                chk;
    leus_pkg::out_word_t exp;
  } typed_t;

  leus_pkg::out_word_t pending_words[$];
  typed_t              typed_q[$];
  int unsigned         n_errors = 0;
  int unsigned         n_sent = 0;
  int unsigned         n_got = 0;
  longint unsigned     n_cycles = 0;

  // directed rows; chk set where the expected word is typed in
  typedef struct {
    leus_pkg::in_word_t  w;
    logic                chk;
    leus_pkg::out_word_t exp;
  } row_t;
  row_t rows[$];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [RW-1:0] got,
                                 input logic [RW-1:0] want);
    $display("MISMATCH %s: got %0h want %0h at cycle %0d", what, got, want, n_cycles);
    n_errors++;
  endtask

  function automatic logic [NW-1:0] lower_canon(input logic [NW-1:0] n);
    logic [NW-1:0] r;
    logic          ended;
    logic [7:0]    c;
    r = '0;
    ended = 1'b0;
    for (int i = 0; i < NB; i++) begin
      c = n[8*i +: 8];
      if (c == 8'h00) ended = 1'b1;
      if (!ended) r[8*i +: 8] = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    end
    return r;
  endfunction

  function automatic logic [NW-1:0] canon_bytes(input logic [NW-1:0] n);
    logic [NW-1:0] r;
    logic          ended;
    r = '0;
    ended = 1'b0;
    for (int i = 0; i < NB; i++) begin
      if (n[8*i +: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[8*i +: 8] = n[8*i +: 8];
    end
    return r;
  endfunction

  function automatic leus_pkg::out_word_t predict_selection(input leus_pkg::in_word_t w);
    leus_pkg::out_word_t o;
    int unsigned         lt, fill, start, pick, k, prev;
    logic [NW-1:0]       key;
    o = '0;
    lt = w.list_type;
    fill = sh_fill[lt];
    case (leus_pkg::cmd_e'(w.cmd))
      leus_pkg::CMD_INSERT: begin
        if (fill >= NENT) o.status = leus_pkg::ST_FULL;
        else begin
          sh_name[lt][fill] = canon_bytes({w.name_hi, w.name_lo});
          sh_count[lt][fill] = 0;
          o.entry_index = 7'(fill);
          sh_fill[lt] = fill + 1;
        end
      end
      leus_pkg::CMD_GET: begin
        if (fill == 0) o.status = leus_pkg::ST_EMPTY;
        else begin
          start = w.start_offset % fill;
          pick = start;
          for (int i = 1; i < fill; i++) begin
            k = (start + i) % fill;
            if (sh_count[lt][k] < sh_count[lt][pick]) pick = k;
          end
          prev = sh_count[lt][pick];
          if (prev < CMAX) sh_count[lt][pick] = prev + 1;
          o.entry_index = 7'(pick);
          {o.out_name_hi, o.out_name_lo} = sh_name[lt][pick];
          if (prev > 0) o.suffix_number = 16'(sh_count[lt][pick]);
        end
      end
      leus_pkg::CMD_COUNT: begin
        o.status = leus_pkg::ST_NOT_FOUND;
        key = lower_canon({w.name_hi, w.name_lo});
        for (int i = 0; i < fill; i++) begin
          if (lower_canon(sh_name[lt][i]) == key) begin
            if (sh_count[lt][i] < CMAX) sh_count[lt][i]++;
            o.status = leus_pkg::ST_OK;
            o.entry_index = 7'(i);
            break;
          end
        end
      end
      default: begin
        for (int l = 0; l < NLIST; l++)
          for (int i = 0; i < NENT; i++) sh_count[l][i] = 0;
      end
    endcase
    return o;
  endfunction

  function automatic leus_pkg::in_word_t make_word(input leus_pkg::cmd_e c, input logic lt,
                                                   input logic [NW-1:0] nm,
                                                   input logic [15:0] offs);
    leus_pkg::in_word_t w;
    w.cmd = c;
    w.list_type = lt;
    {w.name_hi, w.name_lo} = nm;
    w.start_offset = offs;
    return w;
  endfunction

  // names from a small pool so count hits are common; random case, tails and junk
  logic [NW-1:0] pool[8];

  function automatic logic [NW-1:0] pick_name();
    logic [NW-1:0] n;
    logic [7:0]    c;
    logic          ended;
    int unsigned   sel;
    sel = $urandom_range(0, 9);
    if (sel >= 8) return NW'({$urandom, $urandom, $urandom, $urandom});
    n = pool[sel];
    ended = 1'b0;
    for (int i = 0; i < NB; i++) begin
      c = n[8*i +: 8];
      if ($urandom_range(0, 1) && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")))
        n[8*i +: 8] = c ^ 8'h20;
      // garbage after the terminator
      if (ended && $urandom_range(0, 3) == 0) n[8*i +: 8] = 8'($urandom);
      if (c == 8'h00) ended = 1'b1;
    end
    return n;
  endfunction

  // drive one word, with a random gap first
  task automatic send_word(input leus_pkg::in_word_t w, input logic chk,
                           input leus_pkg::out_word_t exp);
    typed_t      t;
    int unsigned gap;
    t.chk = chk;
    t.exp = exp;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    typed_q.push_back(t);
    n_sent++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // acceptance side: predict at the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) pending_words.push_back(predict_selection(in_word_i));
  end

  // result side
  int unsigned stall_left;
  always @(posedge clk_i) begin
    leus_pkg::out_word_t want;
    typed_t              t;
    if (!rst_ni) begin
      out_ready_i <= 1'b1;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_got++;
        if (pending_words.size() == 0 || typed_q.size() == 0) begin
          report_mismatch("unexpected word", RW'(out_word_o), '0);
        end else begin
          want = pending_words.pop_front();
          t = typed_q.pop_front();
          if (t.chk) want = t.exp;
          if (out_word_o.status != want.status)
            report_mismatch("status", RW'(out_word_o.status), RW'(want.status));
          if (out_word_o.entry_index != want.entry_index)
            report_mismatch("entry_index", RW'(out_word_o.entry_index),
                            RW'(want.entry_index));
          if (out_word_o.out_name_lo != want.out_name_lo)
            report_mismatch("out_name_lo", RW'(out_word_o.out_name_lo),
                            RW'(want.out_name_lo));
          if (out_word_o.out_name_hi != want.out_name_hi)
            report_mismatch("out_name_hi", RW'(out_word_o.out_name_hi),
                            RW'(want.out_name_hi));
          if (out_word_o.suffix_number != want.suffix_number)
            report_mismatch("suffix_number", RW'(out_word_o.suffix_number),
                            RW'(want.suffix_number));
        end
        stall_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11);
        out_ready_i <= (stall_left == 0);
      end else if (!out_ready_i) begin
        if (stall_left > 0) stall_left--;
        if (stall_left == 0) out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // typed expectation for directed rows checked by value
  task automatic add_row(input leus_pkg::in_word_t w, input logic chk,
                         input leus_pkg::out_word_t e);
    row_t r;
    r.w = w;
    r.chk = chk;
    r.exp = e;
    rows.push_back(r);
  endtask

  function automatic leus_pkg::out_word_t ow(input leus_pkg::status_e s,
                                             input int unsigned idx);
    leus_pkg::out_word_t o;
    o = '0;
    o.status = s;
    o.entry_index = 7'(idx);
    return o;
  endfunction

  initial begin
    leus_pkg::in_word_t w;
    int unsigned        r;
    logic               lt;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    for (int l = 0; l < NLIST; l++) begin
      sh_fill[l] = 0;
      for (int i = 0; i < NENT; i++) begin
        sh_name[l][i] = '0;
        sh_count[l][i] = 0;
      end
    end
    pool[0] = {"ab", "cdefghijklmno"} ;
    pool[1] = NW'("Alpha");
    pool[2] = NW'("beta");
    pool[3] = NW'("Z@[`{");
    pool[4] = NW'("x");
    pool[5] = NW'("HelloWorld1234");
    pool[6] = '0;
    pool[7] = NW'("mixedCASE");
    // reverse "..." literals so byte 0 is the first character
    for (int p = 0; p < 8; p++) begin
      logic [NW-1:0] t;
      int unsigned   len;
      t = '0;
      len = 0;
      for (int i = NB - 1; i >= 0; i--)
        if (pool[p][8*i +: 8] != 0 && len == 0) len = i + 1;
      for (int i = 0; i < len; i++) t[8*i +: 8] = pool[p][8*(len-1-i) +: 8];
      pool[p] = t;
    end

    // directed table
    add_row(make_word(leus_pkg::CMD_GET, 1'b0, '0, 16'hFFFF), 1'b1,
            ow(leus_pkg::ST_EMPTY, 0));
    add_row(make_word(leus_pkg::CMD_COUNT, 1'b1, pool[1], 16'h0), 1'b1,
            ow(leus_pkg::ST_NOT_FOUND, 0));
    add_row(make_word(leus_pkg::CMD_RESET, 1'b1, '1, 16'hFFFF), 1'b1,
            ow(leus_pkg::ST_OK, 0));
    add_row(make_word(leus_pkg::CMD_INSERT, 1'b0, '1, 16'hFFFF), 1'b1,
            ow(leus_pkg::ST_OK, 0));
    add_row(make_word(leus_pkg::CMD_INSERT, 1'b0, pool[1], 16'h0), 1'b1,
            ow(leus_pkg::ST_OK, 1));
    add_row(make_word(leus_pkg::CMD_INSERT, 1'b0, '0, 16'h0), 1'b1,
            ow(leus_pkg::ST_OK, 2));
    add_row(make_word(leus_pkg::CMD_INSERT, 1'b1, {8'h00, {14{8'h41}}}, 16'h0), 1'b1,
            ow(leus_pkg::ST_OK, 0));
    add_row(make_word(leus_pkg::CMD_GET, 1'b0, '0, 16'hFFFF), 1'b0, '0);
    add_row(make_word(leus_pkg::CMD_GET, 1'b0, '0, 16'h0), 1'b0, '0);
    add_row(make_word(leus_pkg::CMD_GET, 1'b0, '0, 16'h1), 1'b0, '0);
    add_row(make_word(leus_pkg::CMD_GET, 1'b0, '0, 16'h2), 1'b0, '0);
    add_row(make_word(leus_pkg::CMD_COUNT, 1'b0, NW'(64'h41_48_50_4C_61), 16'h0), 1'b0, '0);
    add_row(make_word(leus_pkg::CMD_COUNT, 1'b0,
                      {pool[1][NW-1:48], 8'h00, pool[1][39:0]}, 16'h0), 1'b0, '0);
    add_row(make_word(leus_pkg::CMD_COUNT, 1'b0, '0, 16'h0), 1'b0, '0);
    add_row(make_word(leus_pkg::CMD_COUNT, 1'b1, {8'hFF, {14{8'h61}}}, 16'h0), 1'b0, '0);
    add_row(make_word(leus_pkg::CMD_GET, 1'b1, '1, 16'h8000), 1'b0, '0);
    add_row(make_word(leus_pkg::CMD_RESET, 1'b0, '0, 16'h0), 1'b1,
            ow(leus_pkg::ST_OK, 0));
    add_row(make_word(leus_pkg::CMD_GET, 1'b0, '0, 16'h7), 1'b0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_word(rows[i].w, rows[i].chk, rows[i].exp);

    // random words of all four commands on both lists
    for (r = 0; r < NRAND; r++) begin
      lt = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
        0, 1, 2, 3: w = make_word(leus_pkg::CMD_INSERT, lt, pick_name(), 16'($urandom));
        4, 5, 6, 7, 8, 9, 10: w = make_word(leus_pkg::CMD_GET, lt, pick_name(),
                                            16'($urandom));
        11, 12, 13, 14, 15, 16, 17, 18: w = make_word(leus_pkg::CMD_COUNT, lt, pick_name(),
                                                      16'($urandom));
        default: w = $urandom_range(0, 9) == 0 ?
                     make_word(leus_pkg::CMD_RESET, lt, pick_name(), 16'($urandom)) :
                     make_word(leus_pkg::CMD_GET, lt, pick_name(), 16'($urandom));
      endcase
      // push list 1 toward full early so overflow is seen often
      if (r < 140 && r % 2 == 0)
        w = make_word(leus_pkg::CMD_INSERT, 1'b1, pick_name(), 16'($urandom));
      send_word(w, 1'b0, '0);
      if (r == 300) begin
        // sender holds off until everything is back
        in_valid_i <= 1'b0;
        while (n_got != n_sent) @(posedge clk_i);
      end
    end

    in_valid_i <= 1'b0;
    while (n_got != n_sent) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (n_errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
